[src/priority_task_scheduler_unit_assert.svh]
// Assertion macros for the priority task scheduler
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Check an implication at every clock edge, off during reset
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication, off during reset
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pts_pkg.sv]
// Package: constants and types for the priority task scheduler
package pts_pkg;
    localparam int MaxTasksDefault     = 16;
    localparam int PriorityBitsDefault = 8;
    localparam int SliceBits           = 12;
    localparam logic [SliceBits-1:0] SliceLimit = 12'hFFF;
    localparam logic [3:0] GainReset   = 4'd10;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_EXIT   = 2'd1,
        MODE_RR     = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOSLOT = 2'd1,
        ST_HALTED = 2'd2,
        ST_NOCHG  = 2'd3
    } status_t;
endpackage

[src/priority_task_scheduler_unit.sv]
// Top level: priority scheduler with round robin, sequenced over a shared scan unit
//
//  channel | direction | handshake      | word
//  cfg     | in        | valid / ready  | cfg_data (slice_per_priority)
//  in      | in        | valid / stall  | mode, task_priority
//  out     | out       | valid / stall  | status, running_id, running_valid,
//          |           |                | switched, created_id, time_slice
//
//  An event runs a free slot search, a minimum scan of the queue one entry per
//  cycle, and a compaction of the queue one entry per cycle.
//  Reset clears slot use, queue count, running state and halt; stores need none.
//  The result sits in an output register; a new event is taken once it drains.
//  cfg_ready is high only while the sequencer is idle.
module priority_task_scheduler_unit
    import pts_pkg::*;
#(
    parameter int MAX_TASKS     = MaxTasksDefault,
    parameter int PRIORITY_BITS = PriorityBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  task_priority,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  running_id,
    output logic        running_valid,
    output logic        switched,
    output logic [3:0]  created_id,
    output logic [11:0] time_slice
);
`include "priority_task_scheduler_unit_assert.svh"

    localparam int IdBits  = $clog2(MAX_TASKS);
    localparam int CntBits = $clog2(MAX_TASKS + 1);
    localparam int PB      = PRIORITY_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_FREE, S_CREATE, S_MIN, S_CMP, S_REFILL, S_REMOVE, S_PUSH,
        S_RR_SLICE, S_RR_HEAD, S_FILL, S_DONE
    } state_t;

    state_t                state_reg;
    logic [3:0]            gain_reg;
    logic [MAX_TASKS-1:0]  used_reg;
    logic [CntBits-1:0]    qcnt_reg;
    logic [IdBits-1:0]     cur_reg;
    logic                  curv_reg;
    logic                  halt_reg;
    logic [IdBits-1:0]     prev_id_reg;
    logic                  prev_v_reg;
    logic [1:0]            mode_reg;
    logic [PB-1:0]         prio_reg;
    logic [1:0]            st_reg;
    logic [IdBits-1:0]     created_reg;
    logic [CntBits-1:0]    idx_reg;
    logic [CntBits-1:0]    best_reg;
    logic [PB-1:0]         bestp_reg;
    logic [IdBits-1:0]     bestid_reg;
    logic [IdBits-1:0]     push_reg;
    logic                  pend_reg;
    logic [IdBits-1:0]     sel_reg;
    logic                  mul_pend_reg;
    logic                  outv_reg;
    logic [1:0]            o_st_reg;
    logic [3:0]            o_id_reg;
    logic                  o_v_reg;
    logic                  o_sw_reg;
    logic [3:0]            o_cr_reg;
    logic [11:0]           o_ts_reg;

    logic [PB-1:0]         prio_mem [MAX_TASKS];
    logic [SliceBits-1:0]  slice_mem [MAX_TASKS];
    logic [IdBits-1:0]     queue_mem [MAX_TASKS];

    logic [SliceBits-1:0]  mul_slice;
    logic [PB-1:0]         mul_prio;
    logic                  in_fire;
    logic [IdBits-1:0]     qidx;
    logic [IdBits-1:0]     qid;
    logic [PB-1:0]         qprio;
    logic [PB-1:0]         cur_prio;
    logic [SliceBits-1:0]  cur_slice;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || outv_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign qidx      = idx_reg[IdBits-1:0];
    assign qid       = queue_mem[qidx];
    assign qprio     = prio_mem[qid];
    assign cur_prio  = prio_mem[cur_reg];
    assign cur_slice = slice_mem[cur_reg];
    assign mul_prio  = prio_mem[sel_reg];

    pts_slice_mul #(.PRIORITY_BITS(PB)) u_mul (
        .clk   (clk),
        .prio  (mul_prio),
        .gain  (gain_reg),
        .slice (mul_slice)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CREATE)
            prio_mem[created_reg] <= prio_reg;
        if (state_reg == S_FILL && mul_pend_reg)
            slice_mem[sel_reg] <= mul_slice;
        if (state_reg == S_REMOVE && (idx_reg + 1'b1) < qcnt_reg)
            queue_mem[qidx] <= queue_mem[IdBits'(idx_reg + 1'b1)];
        if (state_reg == S_PUSH && qcnt_reg < CntBits'(MAX_TASKS))
            queue_mem[IdBits'(qcnt_reg)] <= push_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            gain_reg     <= GainReset;
            used_reg     <= '0;
            qcnt_reg     <= '0;
            cur_reg      <= '0;
            curv_reg     <= 1'b0;
            halt_reg     <= 1'b0;
            outv_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            mul_pend_reg <= 1'b0;
        end
        else
        begin
            if (outv_reg && !out_stall)
                outv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        gain_reg <= cfg_data;
                    if (in_fire)
                    begin
                        mode_reg    <= mode;
                        prio_reg    <= PB'(task_priority);
                        prev_id_reg <= cur_reg;
                        prev_v_reg  <= curv_reg;
                        st_reg      <= ST_OK;
                        created_reg <= '0;
                        idx_reg     <= '0;
                        pend_reg    <= 1'b0;
                        if (halt_reg)
                        begin
                            st_reg    <= ST_HALTED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            case (mode)
                                MODE_CREATE: state_reg <= S_FREE;
                                MODE_EXIT:
                                begin
                                    if (!curv_reg)
                                    begin
                                        st_reg    <= ST_NOCHG;
                                        state_reg <= S_DONE;
                                    end
                                    else if (cur_reg == '0)
                                    begin
                                        halt_reg  <= 1'b1;
                                        st_reg    <= ST_HALTED;
                                        state_reg <= S_DONE;
                                    end
                                    else
                                    begin
                                        used_reg[cur_reg] <= 1'b0;
                                        curv_reg  <= 1'b0;
                                        state_reg <= S_MIN;
                                    end
                                end
                                MODE_RR:
                                begin
                                    if (qcnt_reg == '0)
                                    begin
                                        st_reg    <= ST_NOCHG;
                                        state_reg <= S_DONE;
                                    end
                                    else if (curv_reg)
                                    begin
                                        sel_reg   <= cur_reg;
                                        state_reg <= S_RR_SLICE;
                                    end
                                    else
                                        state_reg <= S_RR_HEAD;
                                end
                                default:
                                begin
                                    st_reg    <= ST_NOCHG;
                                    state_reg <= S_DONE;
                                end
                            endcase
                        end
                    end
                end
                S_FREE:
                begin
                    if (idx_reg >= CntBits'(MAX_TASKS))
                    begin
                        st_reg    <= ST_NOSLOT;
                        state_reg <= S_DONE;
                    end
                    else if (!used_reg[qidx])
                    begin
                        created_reg <= qidx;
                        state_reg   <= S_CREATE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_CREATE:
                begin
                    used_reg[created_reg] <= 1'b1;
                    sel_reg      <= created_reg;
                    push_reg     <= created_reg;
                    mul_pend_reg <= 1'b0;
                    pend_reg     <= 1'b1;
                    state_reg    <= S_FILL;
                end
                S_FILL:
                begin
                    // wait for the registered multiplier result, then write
                    if (!mul_pend_reg)
                        mul_pend_reg <= 1'b1;
                    else
                    begin
                        mul_pend_reg <= 1'b0;
                        if (pend_reg && mode_reg == MODE_CREATE)
                            state_reg <= S_PUSH;
                        else if (mode_reg == MODE_RR)
                        begin
                            push_reg  <= cur_reg;
                            state_reg <= S_PUSH;
                        end
                        else
                            state_reg <= S_CMP;
                    end
                end
                S_PUSH:
                begin
                    if (qcnt_reg < CntBits'(MAX_TASKS))
                        qcnt_reg <= qcnt_reg + 1'b1;
                    idx_reg <= '0;
                    if (mode_reg == MODE_RR)
                        state_reg <= S_RR_HEAD;
                    else if (pend_reg)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_MIN;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_MIN:
                begin
                    if (qcnt_reg == '0)
                        state_reg <= S_DONE;
                    else if (idx_reg >= qcnt_reg)
                    begin
                        if (curv_reg && cur_slice == '0)
                        begin
                            sel_reg   <= cur_reg;
                            state_reg <= S_REFILL;
                        end
                        else
                            state_reg <= S_CMP;
                    end
                    else
                    begin
                        if (idx_reg == '0 || qprio < bestp_reg)
                        begin
                            best_reg   <= idx_reg;
                            bestp_reg  <= qprio;
                            bestid_reg <= qid;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_REFILL:
                begin
                    mul_pend_reg <= 1'b0;
                    state_reg    <= S_FILL;
                end
                S_CMP:
                begin
                    if (curv_reg && bestp_reg > cur_prio)
                        state_reg <= S_DONE;
                    else
                    begin
                        idx_reg   <= best_reg;
                        push_reg  <= cur_reg;
                        pend_reg  <= curv_reg;
                        cur_reg   <= bestid_reg;
                        curv_reg  <= 1'b1;
                        state_reg <= S_REMOVE;
                    end
                end
                S_REMOVE:
                begin
                    if ((idx_reg + 1'b1) < qcnt_reg)
                        idx_reg <= idx_reg + 1'b1;
                    else
                    begin
                        qcnt_reg <= qcnt_reg - 1'b1;
                        if (pend_reg && mode_reg != MODE_RR)
                        begin
                            pend_reg  <= 1'b0;
                            state_reg <= S_PUSH;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_RR_SLICE:
                begin
                    mul_pend_reg <= 1'b0;
                    state_reg    <= S_FILL;
                end
                S_RR_HEAD:
                begin
                    cur_reg   <= queue_mem[0];
                    curv_reg  <= 1'b1;
                    idx_reg   <= '0;
                    state_reg <= S_REMOVE;
                end
                S_DONE:
                begin
                    if (!outv_reg || !out_stall)
                    begin
                        outv_reg  <= 1'b1;
                        o_st_reg  <= st_reg;
                        o_v_reg   <= curv_reg;
                        o_id_reg  <= curv_reg ? 4'(cur_reg) : 4'd0;
                        o_sw_reg  <= (curv_reg != prev_v_reg) ||
                                     (curv_reg && cur_reg != prev_id_reg);
                        o_cr_reg  <= 4'(created_reg);
                        o_ts_reg  <= curv_reg ? cur_slice : '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid     = outv_reg;
    assign status        = o_st_reg;
    assign running_id    = o_id_reg;
    assign running_valid = o_v_reg;
    assign switched      = o_sw_reg;
    assign created_id    = o_cr_reg;
    assign time_slice    = o_ts_reg;

    `PTS_ASSERT_IMPL(a_qcnt_bound, clk, rst_n, 1'b1, qcnt_reg <= CntBits'(MAX_TASKS),
        "queue count beyond slot count")
    `PTS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg,
        "halt flag cleared")
    `PTS_ASSERT_IMPL(a_run_used, clk, rst_n, state_reg == S_IDLE && curv_reg,
        used_reg[cur_reg], "running task in a free slot")
    `PTS_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(time_slice), "stalled word changed")
endmodule

[src/pts_slice_mul.sv]
// Slice calculator: priority times gain, saturated, registered
module pts_slice_mul
    import pts_pkg::*;
#(
    parameter int PRIORITY_BITS = PriorityBitsDefault
)
(
    input  logic                     clk,
    input  logic [PRIORITY_BITS-1:0] prio,
    input  logic [3:0]               gain,
    output logic [SliceBits-1:0]     slice
);
    localparam int ProdBits = PRIORITY_BITS + 4;
    logic [ProdBits-1:0] prod;
    logic [SliceBits-1:0] slice_reg;

    assign prod = ProdBits'(prio) * ProdBits'(gain);

    always_ff @(posedge clk)
    begin
        if (prod > ProdBits'(SliceLimit))
            slice_reg <= SliceLimit;
        else
            slice_reg <= SliceBits'(prod);
    end

    assign slice = slice_reg;
endmodule
